// ----- hw/rtl/shadow_map_depth_test_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the shadow map depth test block.
// ---------------------------------------------------------------------------
`ifndef SHADOW_MAP_DEPTH_TEST_MACROS_SVH
`define SHADOW_MAP_DEPTH_TEST_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/smdt_pkg.sv -----
// ---------------------------------------------------------------------------
// smdt_pkg
// Shared types, constants and register codes of the shadow map depth test.
// ---------------------------------------------------------------------------
`default_nettype none
package smdt_pkg;

  localparam int unsigned DefMapWidth  = 256;
  localparam int unsigned DefMapHeight = 256;

  localparam int unsigned DepthW = 24;
  localparam int unsigned AxisW  = 48;
  localparam int unsigned FocalW = 20;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Shadow cause codes.
  typedef enum logic [1:0] {
    CAUSE_COMPARE = 2'd0,
    CAUSE_BEHIND  = 2'd1,
    CAUSE_OFFMAP  = 2'd2,
    CAUSE_NOQUERY = 2'd3
  } cause_e;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_RIGHT  = 3'd0,
    REG_UP     = 3'd1,
    REG_FWD    = 3'd2,
    REG_LX     = 3'd3,
    REG_LY     = 3'd4,
    REG_LZ     = 3'd5,
    REG_FOCAL  = 3'd6,
    REG_BIAS   = 3'd7
  } reg_e;

  localparam logic [47:0] RightReset = 48'd16384;
  localparam logic [47:0] UpReset    = 48'd1073741824;
  localparam logic [47:0] FwdReset   = 48'd70368744177664;
  localparam logic [19:0] FocalReset = 20'd35174;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input item
    logic clr_step;   // clear-sweep write of one entry
    logic dot_step;   // one multiply-accumulate step
    logic proj_step;  // projection numerator step
    logic div_start;  // start the divider
    logic div_step;   // one divider iteration
    logic div_save;   // store divider quotient
    logic mem_rd;     // issue memory read
    logic mem_wr;     // issue memory write
    logic finish;     // form result
  } ctl_cmd_t;

  // Datapath status to controller.
  typedef struct packed {
    logic clr_done;
    logic dot_last;
    logic behind;
    logic div_last;
    logic [1:0] div_sel;
    logic offmap;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/smdt_divider.sv -----
// ---------------------------------------------------------------------------
// smdt_divider
// Restoring divider, one quotient bit per cycle while step_i is high.
// ---------------------------------------------------------------------------
`default_nettype none
module smdt_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 48
) (
  input  wire logic            clk_i,
  input  wire logic            start_i,
  input  wire logic            step_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [NumW-1:0] quot_o
);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;

  // Shift one numerator bit into the remainder and try the subtraction.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (step_i) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ----- hw/rtl/smdt_datapath.sv -----
// ---------------------------------------------------------------------------
// smdt_datapath
// Depth memory, configuration registers and query arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none
module smdt_datapath #(
  parameter int unsigned MapWidth  = smdt_pkg::DefMapWidth,
  parameter int unsigned MapHeight = smdt_pkg::DefMapHeight
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire smdt_pkg::ctl_cmd_t    cmd_i,
  output smdt_pkg::dp_status_t       status_o,
  input  wire logic [1:0]            command_i,
  input  wire logic [15:0]           tex_u_i,
  input  wire logic [15:0]           tex_v_i,
  input  wire logic [23:0]           depth_in_i,
  input  wire logic [31:0]           world_x_i,
  input  wire logic [31:0]           world_y_i,
  input  wire logic [31:0]           world_z_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [47:0]           cfg_data_i,
  output logic      [47:0]           cfg_rdata_o,
  output logic      [23:0]           depth_out_o,
  output logic                       in_shadow_o,
  output logic      [1:0]            shadow_cause_o
);
  import smdt_pkg::*;

  localparam int unsigned Depth = MapWidth * MapHeight;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned UW    = $clog2(MapWidth);
  localparam int unsigned VW    = $clog2(MapHeight);

  // Configuration registers.
  logic [47:0] right_q, up_q, fwd_q;
  logic [31:0] lx_q, ly_q, lz_q;
  logic [19:0] focal_q;
  logic [23:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= RightReset;
      up_q    <= UpReset;
      fwd_q   <= FwdReset;
      lx_q    <= '0;
      ly_q    <= '0;
      lz_q    <= '0;
      focal_q <= FocalReset;
      bias_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_RIGHT: right_q <= cfg_data_i;
        REG_UP:    up_q    <= cfg_data_i;
        REG_FWD:   fwd_q   <= cfg_data_i;
        REG_LX:    lx_q    <= cfg_data_i[31:0];
        REG_LY:    ly_q    <= cfg_data_i[31:0];
        REG_LZ:    lz_q    <= cfg_data_i[31:0];
        REG_FOCAL: focal_q <= cfg_data_i[19:0];
        REG_BIAS:  bias_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(cfg_idx_i))
      REG_RIGHT: cfg_rdata_o = right_q;
      REG_UP:    cfg_rdata_o = up_q;
      REG_FWD:   cfg_rdata_o = fwd_q;
      REG_LX:    cfg_rdata_o = {16'd0, lx_q};
      REG_LY:    cfg_rdata_o = {16'd0, ly_q};
      REG_LZ:    cfg_rdata_o = {16'd0, lz_q};
      REG_FOCAL: cfg_rdata_o = {28'd0, focal_q};
      REG_BIAS:  cfg_rdata_o = {24'd0, bias_q};
      default:   cfg_rdata_o = '0;
    endcase
  end

  // Captured item.
  logic [1:0]  cmd_q;
  logic [15:0] u_q, v_q;
  logic [23:0] din_q;
  logic signed [32:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      u_q   <= tex_u_i;
      v_q   <= tex_v_i;
      din_q <= depth_in_i;
      dx_q  <= $signed({world_x_i[31], world_x_i}) - $signed({lx_q[31], lx_q});
      dy_q  <= $signed({world_y_i[31], world_y_i}) - $signed({ly_q[31], ly_q});
      dz_q  <= $signed({world_z_i[31], world_z_i}) - $signed({lz_q[31], lz_q});
    end
  end

  // Dot products: nine multiply-accumulate steps, one 16x33 product each.
  logic [3:0] mac_cnt_q;
  logic signed [51:0] acc_q [3];
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] prod_q;
  logic [1:0] prod_ax_q;
  logic       prod_vld_q;
  logic [1:0] ax_sel, cp_sel;

  // Step number to axis and component.
  always_comb begin
    unique case (mac_cnt_q)
      4'd0:    begin ax_sel = 2'd0; cp_sel = 2'd0; end
      4'd1:    begin ax_sel = 2'd0; cp_sel = 2'd1; end
      4'd2:    begin ax_sel = 2'd0; cp_sel = 2'd2; end
      4'd3:    begin ax_sel = 2'd1; cp_sel = 2'd0; end
      4'd4:    begin ax_sel = 2'd1; cp_sel = 2'd1; end
      4'd5:    begin ax_sel = 2'd1; cp_sel = 2'd2; end
      4'd6:    begin ax_sel = 2'd2; cp_sel = 2'd0; end
      4'd7:    begin ax_sel = 2'd2; cp_sel = 2'd1; end
      default: begin ax_sel = 2'd2; cp_sel = 2'd2; end
    endcase
  end

  always_comb begin
    unique case (ax_sel)
      2'd0:    mul_a = 16'(right_q >> (16 * cp_sel));
      2'd1:    mul_a = 16'(up_q >> (16 * cp_sel));
      default: mul_a = 16'(fwd_q >> (16 * cp_sel));
    endcase
    unique case (cp_sel)
      2'd0:    mul_b = dx_q;
      2'd1:    mul_b = dy_q;
      default: mul_b = dz_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_cnt_q  <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.dot_step && mac_cnt_q < 4'd9;
      if (cmd_i.load) mac_cnt_q <= '0;
      else if (cmd_i.dot_step && mac_cnt_q < 4'd9) mac_cnt_q <= mac_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    prod_ax_q <= ax_sel;
    if (cmd_i.load) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (prod_vld_q) begin
      acc_q[prod_ax_q] <= acc_q[prod_ax_q] + 52'(prod_q);
    end
  end

  // Floor to Q16.16 (arithmetic shift floors).
  logic signed [37:0] cx, cy, cz;
  assign cx = 38'(acc_q[0] >>> 14);
  assign cy = 38'(acc_q[1] >>> 14);
  assign cz = 38'(acc_q[2] >>> 14);

  // Projection numerators: products cx*f and cy*f, one on each projection step.
  logic signed [58:0] pu_q, pv_q;
  logic signed [46:0] den;
  logic signed [59:0] nu_q, nv_q;
  logic               pstage_q;
  assign den = 47'(cz) <<< 8;

  always_ff @(posedge clk_i) begin
    if (cmd_i.proj_step) begin
      if (!pstage_q) pu_q <= cx * $signed({1'b0, focal_q});
      else pv_q <= cy * $signed({1'b0, focal_q});
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pstage_q <= 1'b0;
    else if (cmd_i.load) pstage_q <= 1'b0;
    else if (cmd_i.proj_step) pstage_q <= ~pstage_q;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && status_o.div_sel == 2'd0) begin
      nu_q <= 60'(den) * 60'(MapWidth / 2) + 60'(pu_q);
      nv_q <= 60'(den) * 60'(MapHeight / 2) - 60'(pv_q);
    end
  end

  // Shared divider: three divisions (u, v, depth), selected by div_sel.
  localparam int unsigned NumW = 64;
  logic [1:0] sel_q;
  logic [6:0] dcnt_q;
  logic [NumW-1:0] dnum;
  logic [NumW-1:0] quot;
  logic [NumW-1:0] qu_q, qv_q, qd_q;
  logic signed [59:0] nu_now;

  assign nu_now = 60'(den) * 60'(MapWidth / 2) + 60'(pu_q);

  always_comb begin
    unique case (sel_q)
      2'd0:    dnum = 64'(nu_now);
      2'd1:    dnum = 64'(nv_q);
      default: dnum = 64'h1_0000_0000;
    endcase
  end

  smdt_divider #(.NumW(NumW), .DenW(48)) u_div (
    .clk_i   (clk_i),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .num_i   (dnum),
    .den_i   (sel_q == 2'd2 ? 48'(cz) : 48'(den)),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) sel_q <= '0;
      else if (cmd_i.div_save) sel_q <= sel_q + 2'd1;
      if (cmd_i.div_start) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_save) begin
      unique case (sel_q)
        2'd0:    qu_q <= quot;
        2'd1:    qv_q <= quot;
        default: qd_q <= quot;
      endcase
    end
  end

  // Texel addressing for read/write and for queries; texel (u, v) sits at (MapHeight-1-v)*MapWidth+u.
  logic        rw_ok, q_ok, is_query;
  logic [AddrW-1:0] rw_addr, q_addr, addr;

  assign is_query = cmd_q == CMD_QUERY;
  assign rw_ok = !u_q[15] && !v_q[15] && 32'(u_q) < MapWidth && 32'(v_q) < MapHeight;
  assign rw_addr = AddrW'((MapHeight - 1 - 32'(v_q[VW-1:0])) * MapWidth
                          + 32'(u_q[UW-1:0]));
  assign q_ok = qu_q < 64'(MapWidth) && qv_q < 64'(MapHeight);
  assign q_addr = AddrW'((MapHeight - 1 - 32'(qv_q[VW-1:0])) * MapWidth
                         + 32'(qu_q[UW-1:0]));

  // Clear sweep counter.
  logic [AddrW:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
  end

  always_comb begin
    priority if (cmd_i.clr_step) addr = clr_q[AddrW-1:0];
    else if (is_query) addr = q_addr;
    else addr = rw_addr;
  end

  // Depth memory.
  logic [23:0] mem [Depth];
  logic [23:0] rd_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem[addr] <= '0;
    else if (cmd_i.mem_wr && rw_ok) mem[addr] <= din_q;
    if (cmd_i.mem_rd) rd_q <= mem[addr];
  end

  // Result formation.
  logic [23:0] qdepth;
  logic signed [25:0] diff;
  assign qdepth = (qd_q > 64'hFF_FFFF) ? 24'hFF_FFFF : qd_q[23:0];
  assign diff = $signed({2'b0, qdepth}) - $signed({2'b0, bias_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      depth_out_o    <= '0;
      in_shadow_o    <= 1'b0;
      shadow_cause_o <= CAUSE_NOQUERY;
      unique case (cmd_e'(cmd_q))
        CMD_READ: if (rw_ok) depth_out_o <= rd_q;
        CMD_QUERY: begin
          in_shadow_o <= 1'b1;
          if (status_o.behind) shadow_cause_o <= CAUSE_BEHIND;
          else if (status_o.offmap) shadow_cause_o <= CAUSE_OFFMAP;
          else begin
            shadow_cause_o <= CAUSE_COMPARE;
            depth_out_o    <= rd_q;
            in_shadow_o    <= diff < $signed({2'b0, rd_q});
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o.clr_done = clr_q == (AddrW+1)'(Depth - 1);
  assign status_o.dot_last = mac_cnt_q == 4'd9 && !prod_vld_q;
  assign status_o.behind   = cz <= 0;
  assign status_o.div_last = dcnt_q == 7'(NumW - 1);
  assign status_o.div_sel  = sel_q;
  assign status_o.offmap   = nu_q < 0 || nv_q < 0 || !q_ok;
endmodule
`default_nettype wire

// ----- hw/rtl/smdt_ctrl.sv -----
// ---------------------------------------------------------------------------
// smdt_ctrl
// Sequencer for clear sweep, item capture, query arithmetic and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
module smdt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           command_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output smdt_pkg::ctl_cmd_t        cmd_o,
  input  wire smdt_pkg::dp_status_t status_i
);
  import smdt_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DOT   = 10'b0000000100,
    S_PROJ  = 10'b0000001000,
    S_DIVST = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_RD    = 10'b0001000000,
    S_WAIT  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] cmd_q;
  logic [1:0] pcnt_q;
  logic accept;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cmd_q   <= '0;
      pcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) cmd_q <= command_i;
      if (state_q == S_PROJ) pcnt_q <= pcnt_q + 2'd1;
      else pcnt_q <= '0;
    end
  end

  // Next state and command decoding.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = (command_i == CMD_QUERY) ? S_DOT : S_RD;
        end
      end
      S_DOT: begin
        cmd_o.dot_step = 1'b1;
        if (status_i.dot_last) state_d = status_i.behind ? S_FIN : S_PROJ;
      end
      S_PROJ: begin
        cmd_o.proj_step = pcnt_q < 2'd2;
        if (pcnt_q == 2'd2) state_d = S_DIVST;
      end
      S_DIVST: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd_o.div_save = 1'b1;
        state_d = (status_i.div_sel == 2'd2) ? S_RD : S_DIVST;
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.mem_wr = cmd_q == CMD_WRITE;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/shadow_map_depth_test.sv -----
// ---------------------------------------------------------------------------
// shadow_map_depth_test
// Light-space depth map with depth write, depth read and shadow query.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         command (tuser), tex_u, tex_v, depth_in, world_x/y/z
// m_axis    out        depth_out, in_shadow, shadow_cause
// apb       in/out     eight light and bias registers
//
// After reset a clearing pass writes zero to every texel, one per cycle; no item
// is accepted until it ends. Reads, writes and the unused command go through
// capture, the memory access, result formation and the output register; a shadow
// query first runs the dot products, projection and three 64-step divisions in
// the shared divider. A query behind the light skips on to result formation.
// One item is handled at a time; a result waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module shadow_map_depth_test #(
  parameter int unsigned MAP_WIDTH  = smdt_pkg::DefMapWidth,
  parameter int unsigned MAP_HEIGHT = smdt_pkg::DefMapHeight
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tuser: command[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  // tdata: tex_u[15:0], tex_v[31:16], depth_in[55:32],
  // world_x[87:56], world_y[119:88], world_z[151:120]
  input  wire logic [151:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata: depth_out[23:0], in_shadow[24], shadow_cause[26:25]
  output logic [31:0]       m_axis_tdata_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import smdt_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic [47:0] rdata;
  logic [23:0] depth_out;
  logic        in_shadow;
  logic [1:0]  cause;

  assign pready = 1'b1;
  assign prdata = {16'd0, rdata};

  smdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .command_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  smdt_datapath #(.MapWidth(MAP_WIDTH), .MapHeight(MAP_HEIGHT)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .command_i      (s_axis_tuser_i),
    .tex_u_i        (s_axis_tdata_i[15:0]),
    .tex_v_i        (s_axis_tdata_i[31:16]),
    .depth_in_i     (s_axis_tdata_i[55:32]),
    .world_x_i      (s_axis_tdata_i[87:56]),
    .world_y_i      (s_axis_tdata_i[119:88]),
    .world_z_i      (s_axis_tdata_i[151:120]),
    .cfg_we_i       (psel && penable && pwrite),
    .cfg_idx_i      (paddr[5:3]),
    .cfg_data_i     (pwdata[47:0]),
    .cfg_rdata_o    (rdata),
    .depth_out_o    (depth_out),
    .in_shadow_o    (in_shadow),
    .shadow_cause_o (cause)
  );

  assign m_axis_tdata_o = {5'd0, cause, in_shadow, depth_out};
endmodule
`default_nettype wire

// ----- hw/rtl/smdt_checker.sv -----
// ---------------------------------------------------------------------------
// smdt_checker
// Port-level checks on the shadow map depth test.
// ---------------------------------------------------------------------------
`default_nettype none
`include "shadow_map_depth_test_macros.svh"
module smdt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o
);
  // One item in flight: no input taken while a result is pending.
  `SMD_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o, "input ready while result pending")
  // An accepted item never shows a result in the next cycle.
  `SMD_ASSERT_NEXT(a_latency, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !m_axis_tvalid_o, "result too early")
  // A non-shadowed result is a depth compare or not a query.
  `SMD_ASSERT_IMP(a_cause, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[24], m_axis_tdata_o[26:25] == 2'd0 || m_axis_tdata_o[26:25] == 2'd3, "bad cause")
  // A stalled result holds.
  `SMD_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed under stall")
endmodule

bind shadow_map_depth_test smdt_checker u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
